### hw/rtl/pcmf_pkg.sv
package pcmf_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CODE_SIGNS  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CODE_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERSAMPLE  = 2'd2;

  localparam int LEN_BITS   = 7;
  localparam int OSR_BITS   = 5;
  localparam int MAX_CODE   = 64;
  localparam int EL_BITS    = 6;
  localparam int OUT_BITS   = 20;
  localparam int SCALE_BITS = 16;
  localparam int SCALE_SHIFT = 15;
  localparam int SCALE_ENTRIES = 128;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_DRAIN,
    ST_MUL,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic mul;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_out;
    logic j_zero;
    logic m_last;
    logic out_free;
  } status_t;

  typedef logic [SCALE_BITS-1:0] scale_tab_t [SCALE_ENTRIES];

  // round(32768/sqrt(t)) as the largest s with (2s-1)^2 * t <= 2^32
  function automatic scale_tab_t build_scale_table();
    scale_tab_t tab;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned d;
    for (int t = 1; t <= SCALE_ENTRIES; t++) begin
      lo = 1;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        d = 2 * mid - 1;
        if (d * d * longint'(t) <= 64'h1_0000_0000) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      tab[t-1] = SCALE_BITS'(lo);
    end
    return tab;
  endfunction

  localparam scale_tab_t SCALE_TABLE = build_scale_table();

endpackage

### hw/rtl/pulse_code_matched_filter_unit.sv
// Binary phase code matched filter for complex radar samples. Taps are the
// code elements of code_signs, each repeated oversample times, capped at
// MAX_TAPS; each pulse gives exactly as many outputs as samples, the last
// sample flushing the outputs still owed (last_of_pulse marks the final one).
// One shared add/subtract unit walks the taps out of a single-port-read sample
// RAM; each output passes the start, read, drain, multiply and output states,
// reading taps - m entries where m is its flush offset. Input is stalled while
// outputs are computed. No clearing pass: a fill count masks stale entries.
// Write configuration only while the block is idle.
module pulse_code_matched_filter_unit #(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pcmf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pcmf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        sample_re,
  input  logic signed [SAMPLE_BITS-1:0]        sample_im,
  input  logic                                 end_of_pulse,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pcmf_pkg::OUT_BITS-1:0] out_re,
  output logic signed [pcmf_pkg::OUT_BITS-1:0] out_im,
  output logic                                 last_of_pulse
);

  pcmf_pkg::cmd_t    cmd;
  pcmf_pkg::status_t status;

  pcmf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  pcmf_datapath #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_re    (sample_re),
    .sample_im    (sample_im),
    .end_of_pulse (end_of_pulse),
    .out_stall    (out_stall),
    .out_re       (out_re),
    .out_im       (out_im),
    .last_of_pulse(last_of_pulse),
    .out_valid    (out_valid),
    .cmd          (cmd),
    .status       (status)
  );

  // The last sample of a pulse always owes at least one output
  a_eop_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_pulse |=> in_stall)
    else $error("end of pulse accepted without output work");

  // A waiting output item is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output register overwritten while stalled");

  // No new sample is taken while a result is being worked out
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !cmd.step && !cmd.mul && !cmd.out_load)
    else $error("sample accepted during output work");

endmodule

### hw/rtl/pcmf_ram.sv
module pcmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/pcmf_ctrl.sv
module pcmf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pcmf_pkg::status_t status,
  output pcmf_pkg::cmd_t    cmd
);

  pcmf_pkg::state_t state;
  pcmf_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      pcmf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.has_out) state_next = pcmf_pkg::ST_START;
        end
      end
      pcmf_pkg::ST_START: begin
        cmd.start = 1'b1;
        state_next = pcmf_pkg::ST_READ;
      end
      pcmf_pkg::ST_READ: begin
        cmd.step = 1'b1;
        if (status.j_zero) state_next = pcmf_pkg::ST_DRAIN;
      end
      pcmf_pkg::ST_DRAIN: begin
        state_next = pcmf_pkg::ST_MUL;
      end
      pcmf_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = pcmf_pkg::ST_OUT;
      end
      pcmf_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = status.m_last ? pcmf_pkg::ST_IDLE : pcmf_pkg::ST_START;
        end
      end
      default: state_next = pcmf_pkg::ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/pcmf_datapath.sv
module pcmf_datapath #(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [pcmf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [pcmf_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]           sample_re,
  input  logic signed [SAMPLE_BITS-1:0]           sample_im,
  input  logic                                    end_of_pulse,
  input  logic                                    out_stall,
  output logic signed [pcmf_pkg::OUT_BITS-1:0]    out_re,
  output logic signed [pcmf_pkg::OUT_BITS-1:0]    out_im,
  output logic                                    last_of_pulse,
  output logic                                    out_valid,
  input  pcmf_pkg::cmd_t                          cmd,
  output pcmf_pkg::status_t                       status
);

  localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW   = $clog2(MAX_TAPS + 1);
  localparam int ACCW = SAMPLE_BITS + TW + 1;
  localparam int PW   = ACCW + pcmf_pkg::SCALE_BITS + 1;
  localparam int OW   = pcmf_pkg::OUT_BITS;

  // Configuration registers
  logic [pcmf_pkg::CFG_DATA_BITS-1:0] code_signs;
  logic [pcmf_pkg::LEN_BITS-1:0]      code_length;
  logic [pcmf_pkg::OSR_BITS-1:0]      oversample;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_signs  <= '0;
      code_length <= pcmf_pkg::LEN_BITS'(1);
      oversample  <= pcmf_pkg::OSR_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcmf_pkg::CFG_CODE_SIGNS:  code_signs  <= cfg_data;
        pcmf_pkg::CFG_CODE_LENGTH: code_length <= cfg_data[pcmf_pkg::LEN_BITS-1:0];
        pcmf_pkg::CFG_OVERSAMPLE:  oversample  <= cfg_data[pcmf_pkg::OSR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Tap count and lag from the configuration
  logic [pcmf_pkg::LEN_BITS-1:0] len_eff;
  logic [pcmf_pkg::OSR_BITS-1:0] osr_eff;
  logic [11:0]                   taps_raw;
  logic [TW-1:0]                 taps;
  logic [TW-1:0]                 delay;

  always_comb begin
    if (code_length == '0) len_eff = pcmf_pkg::LEN_BITS'(1);
    else if (code_length > pcmf_pkg::LEN_BITS'(pcmf_pkg::MAX_CODE))
      len_eff = pcmf_pkg::LEN_BITS'(pcmf_pkg::MAX_CODE);
    else len_eff = code_length;
    osr_eff  = (oversample == '0) ? pcmf_pkg::OSR_BITS'(1) : oversample;
    taps_raw = 12'(len_eff) * 12'(osr_eff);
    taps     = (taps_raw > 12'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(taps_raw);
    delay    = taps - TW'(1) - (taps >> 1);
  end

  // Sample line as a circular buffer; fill marks the live entries
  logic [AW-1:0] wp;
  logic [TW-1:0] fill;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [2*SAMPLE_BITS-1:0] rdata;

  assign waddr = wp + AW'(1);

  pcmf_ram #(
    .WIDTH(2 * SAMPLE_BITS),
    .DEPTH(2 ** AW)
  ) u_line (
    .clk  (clk),
    .we   (cmd.accept),
    .waddr(waddr),
    .wdata({sample_re, sample_im}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Output window of this item
  logic [TW-1:0] m;
  logic [TW-1:0] m_end;
  logic          eop;
  logic          n_ready;

  assign n_ready = (fill >= delay);

  // Walk over the taps: j is the line position, el/sub the code element
  logic [AW-1:0]                j;
  logic [pcmf_pkg::EL_BITS-1:0] el;
  logic [pcmf_pkg::OSR_BITS-1:0] sub;
  logic                         rd_pend;
  logic                         rd_valid;
  logic                         rd_neg;

  assign raddr = wp - j;

  logic signed [ACCW-1:0] acc_re;
  logic signed [ACCW-1:0] acc_im;
  logic signed [ACCW-1:0] x_re;
  logic signed [ACCW-1:0] x_im;
  logic signed [PW-1:0]   prod_re;
  logic signed [PW-1:0]   prod_im;
  logic signed [pcmf_pkg::SCALE_BITS:0] scale;

  assign x_re  = ACCW'($signed(rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
  assign x_im  = ACCW'($signed(rdata[SAMPLE_BITS-1:0]));
  assign scale = $signed({1'b0, pcmf_pkg::SCALE_TABLE[7'(taps - TW'(1))]});

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      fill    <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.step;
      if (cmd.accept) begin
        wp <= waddr;
        if (fill != TW'(MAX_TAPS)) fill <= fill + TW'(1);
      end else if (cmd.out_load && status.m_last && eop) begin
        fill <= '0;
      end
    end
  end

  // Item and tap bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      eop   <= end_of_pulse;
      m     <= n_ready ? '0 : delay - fill;
      m_end <= end_of_pulse ? delay : '0;
    end else if (cmd.out_load) begin
      m <= m + TW'(1);
    end
    if (cmd.start) begin
      j      <= AW'(taps - TW'(1) - m);
      el     <= '0;
      sub    <= '0;
      acc_re <= '0;
      acc_im <= '0;
    end else begin
      if (cmd.step) begin
        j        <= j - AW'(1);
        rd_valid <= (TW'(j) < fill);
        rd_neg   <= code_signs[el];
        if (sub == osr_eff - pcmf_pkg::OSR_BITS'(1)) begin
          sub <= '0;
          el  <= el + pcmf_pkg::EL_BITS'(1);
        end else begin
          sub <= sub + pcmf_pkg::OSR_BITS'(1);
        end
      end
      if (rd_pend && rd_valid) begin
        acc_re <= rd_neg ? acc_re - x_re : acc_re + x_re;
        acc_im <= rd_neg ? acc_im - x_im : acc_im + x_im;
      end
    end
    if (cmd.mul) begin
      prod_re <= PW'(acc_re * scale);
      prod_im <= PW'(acc_im * scale);
    end
  end

  // Round (floor after the half bias) and saturate
  function automatic logic signed [OW-1:0] sat_out(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = (p + PW'(1 << (pcmf_pkg::SCALE_SHIFT - 1))) >>> pcmf_pkg::SCALE_SHIFT;
    if ((&q[PW-1:OW-1]) || !(|q[PW-1:OW-1])) return q[OW-1:0];
    return q[PW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
  endfunction

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_re        <= sat_out(prod_re);
      out_im        <= sat_out(prod_im);
      last_of_pulse <= eop && status.m_last;
    end
  end

  assign status.has_out  = end_of_pulse || n_ready;
  assign status.j_zero   = (j == '0);
  assign status.m_last   = (m == m_end);
  assign status.out_free = !out_valid || !out_stall;

endmodule
